@@ sv/top_k_weight_insert_table_assert.svh @@
// assertion macros shared by the table rtl
`ifndef TOP_K_WEIGHT_INSERT_TABLE_ASSERT_SVH
`define TOP_K_WEIGHT_INSERT_TABLE_ASSERT_SVH

// implication checked in the same cycle
`define TKWIT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tkwit assertion failed");

// consequence checked a fixed number of cycles later
`define TKWIT_ASSERT_AFTER(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error("tkwit assertion failed");

`endif

@@ sv/tkwit_pkg.sv @@
package tkwit_pkg;

   localparam int VERTEX_W     = 12;
   localparam int VERTEX_EXT_W = 17;
   localparam int BONE_W       = 8;
   localparam int IN_WEIGHT_W  = 15;
   localparam int WEIGHT_W     = 16;
   localparam int SHOWN_SLOTS  = 4;

   localparam int DEF_MAX_INFLUENCES = 4;
   localparam int DEF_VERTEX_COUNT   = 4096;

   typedef logic [BONE_W-1:0]   bone_type;
   typedef logic [WEIGHT_W-1:0] weight_type;

   localparam bone_type   EMPTY_BONE   = 8'hFF;
   localparam weight_type EMPTY_WEIGHT = 16'hFFFF;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } state_type;

endpackage

@@ sv/tkwit_insert.sv @@
module tkwit_insert #(
   parameter int MAX_INFLUENCES = tkwit_pkg::DEF_MAX_INFLUENCES
) (
   input  tkwit_pkg::weight_type                        old_weight [MAX_INFLUENCES],
   input  tkwit_pkg::bone_type                          old_bone   [MAX_INFLUENCES],
   input  logic [tkwit_pkg::IN_WEIGHT_W-1:0]            new_weight,
   input  tkwit_pkg::bone_type                          new_bone,
   output tkwit_pkg::weight_type                        upd_weight [MAX_INFLUENCES],
   output tkwit_pkg::bone_type                          upd_bone   [MAX_INFLUENCES],
   output logic                                         inserted
);

   tkwit_pkg::weight_type prev_weight [MAX_INFLUENCES];
   tkwit_pkg::bone_type   prev_bone   [MAX_INFLUENCES];
   logic [MAX_INFLUENCES-1:0] not_greater;

   // slot j after a shift takes what slot j-1 held
   for (genvar j = 0; j < MAX_INFLUENCES; j++) begin : g_prev
      if (j == 0) begin : g_first
         assign prev_weight[j] = old_weight[j];
         assign prev_bone[j]   = old_bone[j];
      end else begin : g_rest
         assign prev_weight[j] = old_weight[j-1];
         assign prev_bone[j]   = old_bone[j-1];
      end
      assign not_greater[j] = $signed(old_weight[j]) <= $signed({1'b0, new_weight});
   end

   always_comb begin
      logic seen;
      seen = 1'b0;
      for (int j = 0; j < MAX_INFLUENCES; j++) begin
         upd_weight[j] = old_weight[j];
         upd_bone[j]   = old_bone[j];
         if (seen) begin
            upd_weight[j] = prev_weight[j];
            upd_bone[j]   = prev_bone[j];
         end else if (not_greater[j]) begin
            // first slot not above the new weight: equal weights go behind the newcomer
            upd_weight[j] = {1'b0, new_weight};
            upd_bone[j]   = new_bone;
            seen          = 1'b1;
         end
      end
   end

   assign inserted = |not_greater;

endmodule

@@ sv/top_k_weight_insert_table.sv @@
// channel   direction  handshake            payload
// req       in         start high, busy low vertex_index, bone_number, influence_weight
// rsp       out        rsp_strobe, 1 cycle  vertex_echo, inserted, bone_slot0..3, weight_slot0..3
//
// one word accepted per cycle while busy is low; its response strobe is registered in s1_valid_ff, then rsp_strobe_ff
// the entry read is registered, then updated and written back; a word for the vertex
// written in the same cycle takes the update from a forwarding register
// after reset the tables are cleared one vertex a cycle, addresses 0 to VERTEX_COUNT-1, busy high
// the receiver cannot stall, so busy only reflects the clearing pass
module top_k_weight_insert_table #(
   parameter int MAX_INFLUENCES = tkwit_pkg::DEF_MAX_INFLUENCES,
   parameter int VERTEX_COUNT   = tkwit_pkg::DEF_VERTEX_COUNT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [tkwit_pkg::VERTEX_W-1:0]      req_vertex_index,
   input  logic [tkwit_pkg::BONE_W-1:0]        req_bone_number,
   input  logic [tkwit_pkg::IN_WEIGHT_W-1:0]   req_influence_weight,
   output logic                                rsp_strobe,
   output logic [tkwit_pkg::VERTEX_W-1:0]      rsp_vertex_echo,
   output logic                                rsp_inserted,
   output logic [tkwit_pkg::BONE_W-1:0]        rsp_bone_slot0,
   output logic [tkwit_pkg::BONE_W-1:0]        rsp_bone_slot1,
   output logic [tkwit_pkg::BONE_W-1:0]        rsp_bone_slot2,
   output logic [tkwit_pkg::BONE_W-1:0]        rsp_bone_slot3,
   output logic signed [tkwit_pkg::WEIGHT_W-1:0] rsp_weight_slot0,
   output logic signed [tkwit_pkg::WEIGHT_W-1:0] rsp_weight_slot1,
   output logic signed [tkwit_pkg::WEIGHT_W-1:0] rsp_weight_slot2,
   output logic signed [tkwit_pkg::WEIGHT_W-1:0] rsp_weight_slot3
);

   localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
   localparam int M  = MAX_INFLUENCES;
   localparam int SS = tkwit_pkg::SHOWN_SLOTS;

   // vertex tables
   tkwit_pkg::weight_type [M-1:0] weight_mem [VERTEX_COUNT];
   tkwit_pkg::bone_type   [M-1:0] bone_mem   [VERTEX_COUNT];

   tkwit_pkg::state_type state_ff, state_in;
   logic [AW-1:0]        clr_addr_ff, clr_addr_in;

   logic                              accept;
   logic [tkwit_pkg::VERTEX_EXT_W-1:0] vertex_ext;
   logic [AW-1:0]                     rd_addr;
   logic                              rd_inrange;

   tkwit_pkg::weight_type [M-1:0] rd_weight_ff;
   tkwit_pkg::bone_type   [M-1:0] rd_bone_ff;

   logic                                s1_valid_ff;
   logic                                s1_inrange_ff;
   logic [AW-1:0]                       s1_addr_ff;
   logic [tkwit_pkg::VERTEX_W-1:0]      s1_vertex_ff;
   tkwit_pkg::bone_type                 s1_bone_ff;
   logic [tkwit_pkg::IN_WEIGHT_W-1:0]   s1_weight_ff;

   logic                          fwd_sel_ff;
   tkwit_pkg::weight_type [M-1:0] fwd_weight_ff;
   tkwit_pkg::bone_type   [M-1:0] fwd_bone_ff;

   tkwit_pkg::weight_type old_weight [M];
   tkwit_pkg::bone_type   old_bone   [M];
   tkwit_pkg::weight_type upd_weight [M];
   tkwit_pkg::bone_type   upd_bone   [M];
   tkwit_pkg::weight_type [M-1:0] upd_weight_pk;
   tkwit_pkg::bone_type   [M-1:0] upd_bone_pk;
   logic                  upd_inserted;

   logic                          upd_wr;
   logic                          mem_wr;
   logic [AW-1:0]                 mem_wr_addr;
   tkwit_pkg::weight_type [M-1:0] mem_wr_weight;
   tkwit_pkg::bone_type   [M-1:0] mem_wr_bone;

   tkwit_pkg::weight_type show_weight [SS];
   tkwit_pkg::bone_type   show_bone   [SS];

   logic                           rsp_strobe_ff;
   logic [tkwit_pkg::VERTEX_W-1:0] rsp_vertex_ff;
   logic                           rsp_inserted_ff;
   tkwit_pkg::weight_type          rsp_weight_ff [SS];
   tkwit_pkg::bone_type            rsp_bone_ff   [SS];

   // clearing sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= tkwit_pkg::ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      busy        = 1'b0;
      case (state_ff)
         tkwit_pkg::ST_CLEAR: begin
            busy        = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(VERTEX_COUNT - 1)) begin
               state_in    = tkwit_pkg::ST_RUN;
               clr_addr_in = '0;
            end
         end
         tkwit_pkg::ST_RUN: begin
            state_in = tkwit_pkg::ST_RUN;
         end
         default: begin
            busy        = 1'b1;
            state_in    = tkwit_pkg::ST_CLEAR;
            clr_addr_in = '0;
         end
      endcase
   end

   assign accept     = start && !busy;
   assign vertex_ext = tkwit_pkg::VERTEX_EXT_W'(req_vertex_index);
   assign rd_addr    = vertex_ext[AW-1:0];
   assign rd_inrange = vertex_ext < tkwit_pkg::VERTEX_EXT_W'(VERTEX_COUNT);

   // read side
   always_ff @(posedge clock) begin
      rd_weight_ff <= weight_mem[rd_addr];
      rd_bone_ff   <= bone_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_sel_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         // the entry being written now would be read stale
         fwd_sel_ff  <= accept && upd_wr && (rd_addr == s1_addr_ff);
      end
   end

   always_ff @(posedge clock) begin
      s1_inrange_ff <= rd_inrange;
      s1_addr_ff    <= rd_addr;
      s1_vertex_ff  <= req_vertex_index;
      s1_bone_ff    <= req_bone_number;
      s1_weight_ff  <= req_influence_weight;
      fwd_weight_ff <= upd_weight_pk;
      fwd_bone_ff   <= upd_bone_pk;
   end

   // update
   for (genvar j = 0; j < M; j++) begin : g_old
      assign old_weight[j]    = fwd_sel_ff ? fwd_weight_ff[j] : rd_weight_ff[j];
      assign old_bone[j]      = fwd_sel_ff ? fwd_bone_ff[j]   : rd_bone_ff[j];
      assign upd_weight_pk[j] = upd_weight[j];
      assign upd_bone_pk[j]   = upd_bone[j];
   end

   tkwit_insert #(
      .MAX_INFLUENCES(M)
   ) u_insert (
      .old_weight (old_weight),
      .old_bone   (old_bone),
      .new_weight (s1_weight_ff),
      .new_bone   (s1_bone_ff),
      .upd_weight (upd_weight),
      .upd_bone   (upd_bone),
      .inserted   (upd_inserted)
   );

   // write side: clearing pass or write-back
   assign upd_wr      = s1_valid_ff && s1_inrange_ff;
   assign mem_wr      = busy || upd_wr;
   assign mem_wr_addr = busy ? clr_addr_ff : s1_addr_ff;

   always_comb begin
      for (int j = 0; j < M; j++) begin
         mem_wr_weight[j] = busy ? tkwit_pkg::EMPTY_WEIGHT : upd_weight[j];
         mem_wr_bone[j]   = busy ? tkwit_pkg::EMPTY_BONE   : upd_bone[j];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         weight_mem[mem_wr_addr] <= mem_wr_weight;
         bone_mem[mem_wr_addr]   <= mem_wr_bone;
      end
   end

   // response word: four slots shown, missing ones and all of an out-of-range vertex empty
   for (genvar s = 0; s < SS; s++) begin : g_show
      if (s < M) begin : g_have
         assign show_weight[s] = s1_inrange_ff ? upd_weight[s] : tkwit_pkg::EMPTY_WEIGHT;
         assign show_bone[s]   = s1_inrange_ff ? upd_bone[s]   : tkwit_pkg::EMPTY_BONE;
      end else begin : g_none
         assign show_weight[s] = tkwit_pkg::EMPTY_WEIGHT;
         assign show_bone[s]   = tkwit_pkg::EMPTY_BONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_vertex_ff   <= s1_vertex_ff;
      rsp_inserted_ff <= upd_inserted && s1_inrange_ff;
      rsp_weight_ff   <= show_weight;
      rsp_bone_ff     <= show_bone;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_vertex_echo  = rsp_vertex_ff;
   assign rsp_inserted     = rsp_inserted_ff;
   assign rsp_bone_slot0   = rsp_bone_ff[0];
   assign rsp_bone_slot1   = rsp_bone_ff[1];
   assign rsp_bone_slot2   = rsp_bone_ff[2];
   assign rsp_bone_slot3   = rsp_bone_ff[3];
   assign rsp_weight_slot0 = rsp_weight_ff[0];
   assign rsp_weight_slot1 = rsp_weight_ff[1];
   assign rsp_weight_slot2 = rsp_weight_ff[2];
   assign rsp_weight_slot3 = rsp_weight_ff[3];

`include "top_k_weight_insert_table_assert.svh"

   `TKWIT_ASSERT_NOW(a_no_rsp_while_clearing, clock, reset, busy, !rsp_strobe)
   `TKWIT_ASSERT_AFTER(a_rsp_two_after_accept, clock, reset, accept, 2, rsp_strobe)
   `TKWIT_ASSERT_NOW(a_rsp_sorted, clock, reset, rsp_strobe,
      (rsp_weight_slot0 >= rsp_weight_slot1) && (rsp_weight_slot1 >= rsp_weight_slot2) &&
      (rsp_weight_slot2 >= rsp_weight_slot3))

endmodule
